// ===== rtl/core/orqm_pkg.sv =====
// ----------------------------------------------------------------------------
// orqm_pkg
// Shared types and constants for the overwrite-oldest ring queue with mean.
// ----------------------------------------------------------------------------
package orqm_pkg;

    // field widths
    localparam int ID_W     = 16;
    localparam int HEIGHT_W = 9;

    // default queue depth
    localparam int CAPACITY_DEF = 5;

    // largest height value, used in bounds
    localparam int MAX_HEIGHT = (1 << HEIGHT_W) - 1;

    // command codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // input transfer payload
    typedef struct packed {
        logic                opcode;
        logic [ID_W-1:0]     player_id;
        logic [HEIGHT_W-1:0] player_height;
    } in_t;

    // result transfer payload
    typedef struct packed {
        logic [HEIGHT_W-1:0] mean_height;
        logic [ID_W-1:0]     removed_id;
        logic [HEIGHT_W-1:0] removed_height;
        logic                empty_error;
    } out_t;

    // one held entry
    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [HEIGHT_W-1:0] height;
    } entry_t;

    // per-cell control from the queue controller
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/core/orqm_cell.sv =====
// ----------------------------------------------------------------------------
// orqm_cell
// One storage cell of the queue chain. Takes a new entry on load, or the
// entry of its younger neighbour on shift, and otherwise holds.
// ----------------------------------------------------------------------------
module orqm_cell (
    input  logic                aclk,
    input  orqm_pkg::cell_ctrl_t ctrl,
    input  orqm_pkg::entry_t    new_entry,
    input  orqm_pkg::entry_t    nbr_entry,
    output orqm_pkg::entry_t    entry
);

    orqm_pkg::entry_t entry_reg;
    orqm_pkg::entry_t entry_next;

    // load has priority over shift
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.load) begin
            entry_next = new_entry;
        end else if (ctrl.shift) begin
            entry_next = nbr_entry;
        end
    end

    // payload storage, no reset
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/core/orqm_div.sv =====
// ----------------------------------------------------------------------------
// orqm_div
// Serial restoring divider for the mean: one quotient bit per cycle, then
// rounding up when five times the remainder exceeds twice the divisor.
// ----------------------------------------------------------------------------
module orqm_div #(
    parameter int CNT_W = 3
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic [orqm_pkg::HEIGHT_W+CNT_W-1:0]    dividend,
    input  logic [CNT_W-1:0]                       divisor,
    output logic                                   done,
    output logic [orqm_pkg::HEIGHT_W-1:0]          mean
);

    localparam int QUO_W     = orqm_pkg::HEIGHT_W;
    localparam int DVD_W     = QUO_W + CNT_W;
    localparam int STEP_W    = $clog2(QUO_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUO_W - 1);

    logic [CNT_W-1:0]  rem_reg,  rem_next;
    logic [QUO_W-1:0]  qsh_reg,  qsh_next;
    logic [CNT_W-1:0]  dsr_reg,  dsr_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [CNT_W:0]    trial;
    logic [CNT_W-1:0]  diff;
    logic              ge;
    logic [CNT_W+2:0]  rem_x5;
    logic [CNT_W+2:0]  dsr_x2;
    logic              round_up;

    // trial subtraction of one step; the partial remainder stays below the
    // divisor, so the difference fits the divisor width whenever it is kept
    always_comb begin
        trial = {rem_reg, qsh_reg[QUO_W-1]};
        diff  = trial[CNT_W-1:0] - dsr_reg;
        ge    = trial >= {1'b0, dsr_reg};
    end

    // step control and datapath
    always_comb begin
        rem_next  = rem_reg;
        qsh_next  = qsh_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend[DVD_W-1:QUO_W];
            qsh_next  = dividend[QUO_W-1:0];
            dsr_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? diff : trial[CNT_W-1:0];
            qsh_next  = {qsh_reg[QUO_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // operand registers, no reset
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        qsh_reg <= qsh_next;
        dsr_reg <= dsr_next;
    end

    // rounding: up when the fraction exceeds 0.4
    always_comb begin
        rem_x5   = {1'b0, rem_reg, 2'b00} + {3'b000, rem_reg};
        dsr_x2   = {2'b00, dsr_reg, 1'b0};
        round_up = rem_x5 > dsr_x2;
    end

    assign done = done_reg;
    assign mean = qsh_reg + QUO_W'(round_up);

endmodule

// ===== rtl/core/overwrite_ring_queue_with_mean.sv =====
// ----------------------------------------------------------------------------
// overwrite_ring_queue_with_mean
// Fixed-depth queue of (id, height) entries that drops its oldest entry on
// an insert when full and reports the rounded mean height after each insert.
// ----------------------------------------------------------------------------
// The queue is a chain of CAPACITY cells with the oldest entry in the first
// cell; a remove or an overwriting insert shifts every cell one place
// towards the head. One item is in work at a time. A remove (or a remove
// from an empty queue, flagged by empty_error) passes from its transfer
// into the result register and then into the output register, which
// raises m_valid. An insert first loads the serial divider, which then
// forms its nine quotient bits; the rounding goes into the result register
// and then into the output register. A new item is taken once the
// previous result has moved into the output register, even while that
// result still waits for m_ready.
// ----------------------------------------------------------------------------
module overwrite_ring_queue_with_mean #(
    parameter int CAPACITY = orqm_pkg::CAPACITY_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  orqm_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output orqm_pkg::out_t  m_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = orqm_pkg::HEIGHT_W + CNT_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    orqm_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] sum_reg,   sum_next;
    orqm_pkg::out_t   res_reg,   res_next;
    logic             m_valid_reg, m_valid_next;
    orqm_pkg::out_t   m_data_reg,  m_data_next;

    orqm_pkg::entry_t     cell_q    [CAPACITY];
    orqm_pkg::cell_ctrl_t cell_ctrl [CAPACITY];
    orqm_pkg::entry_t     new_entry;

    logic                            acc;
    logic                            is_full;
    logic                            is_insert;
    logic                            do_shift;
    logic                            out_load;
    logic                            div_start;
    logic                            div_done;
    logic [orqm_pkg::HEIGHT_W-1:0]   div_mean;

    assign acc       = s_valid && s_ready;
    assign is_full   = count_reg == CNT_FULL;
    assign is_insert = s_data.opcode == orqm_pkg::OP_INSERT;
    assign new_entry = '{id: s_data.player_id, height: s_data.player_height};

    // cell chain
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            if (gi == CAPACITY - 1) begin : g_tail
                orqm_cell u_cell (
                    .aclk      (aclk),
                    .ctrl      (cell_ctrl[gi]),
                    .new_entry (new_entry),
                    .nbr_entry (cell_q[gi]),
                    .entry     (cell_q[gi])
                );
            end else begin : g_body
                orqm_cell u_cell (
                    .aclk      (aclk),
                    .ctrl      (cell_ctrl[gi]),
                    .new_entry (new_entry),
                    .nbr_entry (cell_q[gi+1]),
                    .entry     (cell_q[gi])
                );
            end
        end
    endgenerate

    // cell control: shift on remove or overwrite, load at the first free slot, or at the last cell when full
    always_comb begin
        do_shift = acc && ((is_insert && is_full) || (!is_insert && count_reg != '0));
        for (int i = 0; i < CAPACITY; i++) begin
            cell_ctrl[i].shift = do_shift;
            cell_ctrl[i].load  = acc && is_insert &&
                                 (is_full ? (i == CAPACITY - 1)
                                          : (count_reg == CNT_W'(i)));
        end
    end

    // mean divider
    orqm_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (count_next),
        .done     (div_done),
        .mean     (div_mean)
    );

    // controller: next state, queue bookkeeping and result
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        res_next   = res_reg;
        s_ready    = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            orqm_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (acc) begin
                    if (is_insert) begin
                        if (is_full) begin
                            sum_next = sum_reg - SUM_W'(cell_q[0].height)
                                     + SUM_W'(s_data.player_height);
                        end else begin
                            sum_next   = sum_reg + SUM_W'(s_data.player_height);
                            count_next = count_reg + 1'b1;
                        end
                        div_start  = 1'b1;
                        state_next = orqm_pkg::ST_DIV;
                    end else begin
                        res_next = '0;
                        if (count_reg == '0) begin
                            res_next.empty_error = 1'b1;
                        end else begin
                            res_next.removed_id     = cell_q[0].id;
                            res_next.removed_height = cell_q[0].height;
                            sum_next   = sum_reg - SUM_W'(cell_q[0].height);
                            count_next = count_reg - 1'b1;
                        end
                        state_next = orqm_pkg::ST_DONE;
                    end
                end
            end
            orqm_pkg::ST_DIV: begin
                if (div_done) begin
                    res_next             = '0;
                    res_next.mean_height = div_mean;
                    state_next           = orqm_pkg::ST_DONE;
                end
            end
            orqm_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = orqm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = orqm_pkg::ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        m_data_next  = out_load ? res_reg : m_data_reg;
        m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= orqm_pkg::ST_IDLE;
            count_reg   <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // fill level never exceeds the depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("queue fill level above depth");

    // height sum stays within what the held entries can add up to
    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (2 * SUM_W)'(sum_reg) <= (2 * SUM_W)'(count_reg) * (2 * SUM_W)'(orqm_pkg::MAX_HEIGHT))
        else $error("height sum out of range");

    // a remove from an empty queue flags the error and leaves the fill level
    a_empty_remove: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && !is_insert && count_reg == '0) |=>
        (state_reg == orqm_pkg::ST_DONE && res_reg.empty_error && count_reg == '0))
        else $error("empty remove not flagged");

    // an insert always leaves the queue non-empty
    a_insert_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && is_insert) |=> (count_reg != '0 && state_reg == orqm_pkg::ST_DIV))
        else $error("insert did not fill a slot");

    // the divider only finishes while the controller waits for it
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == orqm_pkg::ST_DIV)
        else $error("divider result outside division phase");

endmodule
